/* hw/rtl/gdr_pkg.sv */
// ---------------------------------------------------------------------------
// gdr_pkg
// Shared types and constants of the grid DDA ray caster.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdr_pkg;

  localparam int unsigned MAP_DIM_DEF      = 64;
  localparam int unsigned SCREEN_WIDTH_DEF = 512;

  // shared iterative divider
  localparam int unsigned DIV_NW = 33;
  localparam int unsigned DIV_DW = 20;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [1:0] SIDE_WEST  = 2'd0;
  localparam logic [1:0] SIDE_EAST  = 2'd1;
  localparam logic [1:0] SIDE_NORTH = 2'd2;
  localparam logic [1:0] SIDE_SOUTH = 2'd3;

  typedef enum logic [2:0] {
    REG_MAP_COLS    = 3'd0,
    REG_MAP_ROWS    = 3'd1,
    REG_CAM_POS_X   = 3'd2,
    REG_CAM_POS_Y   = 3'd3,
    REG_VIEW_DIR_X  = 3'd4,
    REG_VIEW_DIR_Y  = 3'd5,
    REG_CAM_PLANE_X = 3'd6,
    REG_CAM_PLANE_Y = 3'd7
  } reg_idx_e;

  typedef enum logic {
    DIV_X = 1'b0,
    DIV_Y = 1'b1
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_RAY,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_SIDE,
    ST_STEP,
    ST_CHECK
  } gdr_state_e;

  typedef struct packed {
    logic       cmd;
    logic [8:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_wall;
  } gdr_in_t;

  typedef struct packed {
    logic [1:0]  wall_side;
    logic        wall_hit;
    logic [7:0]  hit_cell_x;
    logic [7:0]  hit_cell_y;
    logic [31:0] final_side_dist_x;
    logic [31:0] final_side_dist_y;
  } gdr_out_t;

  typedef struct packed {
    logic [6:0]  map_cols;
    logic [6:0]  map_rows;
    logic [21:0] cam_pos_x;
    logic [21:0] cam_pos_y;
    logic [17:0] view_dir_x;
    logic [17:0] view_dir_y;
    logic [17:0] cam_plane_x;
    logic [17:0] cam_plane_y;
  } gdr_cfg_t;

  typedef struct packed {
    logic     clr_en;
    logic     cam_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_cap;
    logic     mul_en;
    logic     ray_en;
    logic     side_en;
    logic     step_en;
    logic     emit;
  } gdr_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic oob;
    logic wall;
  } gdr_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/grid_dda_ray_caster.sv */
// ---------------------------------------------------------------------------
// grid_dda_ray_caster
// Wall-map ray caster: per screen column, walks the grid cell by cell.
// ---------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------
//  input    | start & !busy                 | in_i  (gdr_in_t)
//  result   | done_o, one cycle, no stall   | res_o (gdr_out_t)
//  config   | APB, psel&penable&pwrite      | pwdata / prdata
//
//  A cast beat runs the camera offset and the ST_MUL and ST_RAY set-up,
//  two passes of the shared divider for the reciprocals, ST_SIDE, and then
//  ST_STEP and ST_CHECK for each cell walked, for the registered map read.
//  After reset a clearing sweep over all MAP_DIM*MAP_DIM cells holds busy high.
//  The result strobe lasts one cycle; the next beat may be taken meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_dda_ray_caster #(
  parameter int unsigned MAP_DIM      = gdr_pkg::MAP_DIM_DEF,
  parameter int unsigned SCREEN_WIDTH = gdr_pkg::SCREEN_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire gdr_pkg::gdr_in_t in_i,
  output logic                  done_o,
  output gdr_pkg::gdr_out_t     res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import gdr_pkg::*;

  gdr_cfg_t cfg_q;
  gdr_ctl_t ctl;
  gdr_sts_t sts;
  reg_idx_e ridx;
  logic     cfg_we, wr_en;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[4:2]);
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_cols    <= 7'd64;
      cfg_q.map_rows    <= 7'd64;
      cfg_q.cam_pos_x   <= 22'd98304;
      cfg_q.cam_pos_y   <= 22'd98304;
      cfg_q.view_dir_x  <= 18'd65536;
      cfg_q.view_dir_y  <= 18'd0;
      cfg_q.cam_plane_x <= 18'd0;
      cfg_q.cam_plane_y <= 18'd43254;
    end else if (cfg_we) begin
      case (ridx)
        REG_MAP_COLS:    cfg_q.map_cols    <= pwdata[6:0];
        REG_MAP_ROWS:    cfg_q.map_rows    <= pwdata[6:0];
        REG_CAM_POS_X:   cfg_q.cam_pos_x   <= pwdata[21:0];
        REG_CAM_POS_Y:   cfg_q.cam_pos_y   <= pwdata[21:0];
        REG_VIEW_DIR_X:  cfg_q.view_dir_x  <= pwdata[17:0];
        REG_VIEW_DIR_Y:  cfg_q.view_dir_y  <= pwdata[17:0];
        REG_CAM_PLANE_X: cfg_q.cam_plane_x <= pwdata[17:0];
        REG_CAM_PLANE_Y: cfg_q.cam_plane_y <= pwdata[17:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MAP_COLS:    prdata = 32'(cfg_q.map_cols);
      REG_MAP_ROWS:    prdata = 32'(cfg_q.map_rows);
      REG_CAM_POS_X:   prdata = 32'(cfg_q.cam_pos_x);
      REG_CAM_POS_Y:   prdata = 32'(cfg_q.cam_pos_y);
      REG_VIEW_DIR_X:  prdata = 32'(cfg_q.view_dir_x);
      REG_VIEW_DIR_Y:  prdata = 32'(cfg_q.view_dir_y);
      REG_CAM_PLANE_X: prdata = 32'(cfg_q.cam_plane_x);
      REG_CAM_PLANE_Y: prdata = 32'(cfg_q.cam_plane_y);
      default:         prdata = '0;
    endcase
  end

  assign wr_en = start && !busy && in_i.cmd == CMD_WRITE;

  gdr_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .cmd_i (in_i.cmd),
    .sts_i (sts),
    .ctl_o (ctl),
    .busy_o(busy),
    .done_o(done_o)
  );

  gdr_dp #(
    .MAP_DIM     (MAP_DIM),
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .cfg_i  (cfg_q),
    .wr_en_i(wr_en),
    .in_i   (in_i),
    .res_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  a_done_from_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a cast in flight");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.cmd == CMD_CAST) |=> busy)
    else $error("cast beat not taken up");
`endif

endmodule

`default_nettype wire

/* hw/rtl/gdr_div.sv */
// ---------------------------------------------------------------------------
// gdr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdr_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [gdr_pkg::DIV_NW-1:0] dividend_i,
  input  wire logic [gdr_pkg::DIV_DW-1:0] divisor_i,
  output logic                           done_o,
  output logic [gdr_pkg::DIV_NW-1:0]     quot_o
);
  import gdr_pkg::*;

  localparam int unsigned CNTW = $clog2(DIV_NW + 1);

  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              active_q, active_d;
  logic [DIV_DW-1:0] rem_q, rem_d, dvs_q;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    if (start_i) begin
      cnt_d    = CNTW'(DIV_NW);
      active_d = 1'b1;
      rem_d    = '0;
      quo_d    = dividend_i;
    end else if (active_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNTW'(1);
        rem_d = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], ge};
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = active_q && (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/gdr_dp.sv */
// ---------------------------------------------------------------------------
// gdr_dp
// Datapath: wall map, ray set-up arithmetic and the DDA step registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdr_dp #(
  parameter int unsigned MAP_DIM      = gdr_pkg::MAP_DIM_DEF,
  parameter int unsigned SCREEN_WIDTH = gdr_pkg::SCREEN_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gdr_pkg::gdr_ctl_t ctl_i,
  output gdr_pkg::gdr_sts_t      sts_o,
  input  wire gdr_pkg::gdr_cfg_t cfg_i,
  input  wire logic              wr_en_i,
  input  wire gdr_pkg::gdr_in_t  in_i,
  output gdr_pkg::gdr_out_t      res_o
);
  import gdr_pkg::*;

  localparam int unsigned DEPTH = MAP_DIM * MAP_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CB    = ($clog2(MAP_DIM + 1) > 7) ? $clog2(MAP_DIM + 1) : 7;
  localparam int unsigned CW    = CB + 1;

  // camera offset by reciprocal multiplication, exact for any 9-bit column
  localparam int unsigned CAM_SH = 21;
  localparam logic [37:0] CAM_M  =
    38'(((64'd1 << (CAM_SH + 17)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  // wall map and clearing sweep
  logic          mem_q [DEPTH];
  logic [AW-1:0] clr_q;
  logic [AW-1:0] waddr, raddr;
  logic          we, wdata, rdata_q;
  logic          cell_ok;

  assign cell_ok = (int'(in_i.cell_x) < MAP_DIM) && (int'(in_i.cell_y) < MAP_DIM);
  assign we      = ctl_i.clr_en || (wr_en_i && cell_ok);
  assign wdata   = ctl_i.clr_en ? 1'b0 : in_i.cell_wall;
  assign waddr   = ctl_i.clr_en ? clr_q
                 : AW'(AW'(in_i.cell_y) * AW'(MAP_DIM) + AW'(in_i.cell_x));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_en) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // divider operands
  logic [8:0]        colc;
  logic [46:0]       cam_prod;
  logic [DIV_NW-1:0] dividend;
  logic [DIV_DW-1:0] divisor, mag_x, mag_y;
  logic [DIV_NW-1:0] quot;
  logic              div_done;
  logic signed [20:0] rx_q, ry_q;
  logic signed [20:0] nrx, nry;

  assign colc = (int'(in_i.column) >= SCREEN_WIDTH) ? 9'(SCREEN_WIDTH - 1) : in_i.column;
  assign cam_prod = 47'(colc) * 47'(CAM_M);
  assign nrx  = -rx_q;
  assign nry  = -ry_q;
  assign mag_x = rx_q[20] ? DIV_DW'(nrx) : DIV_DW'(rx_q);
  assign mag_y = ry_q[20] ? DIV_DW'(nry) : DIV_DW'(ry_q);

  always_comb begin
    case (ctl_i.div_sel)
      DIV_X: begin
        dividend = {1'b1, 32'b0};
        divisor  = mag_x;
      end
      DIV_Y: begin
        dividend = {1'b1, 32'b0};
        divisor  = mag_y;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  gdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  function automatic logic [31:0] recip_sat(input logic [DIV_DW-1:0] mag,
                                            input logic [DIV_NW-1:0] q);
    if (mag == '0 || q[32]) begin
      return 32'hFFFF_FFFF;
    end
    return q[31:0];
  endfunction

  // ray set-up
  logic signed [17:0] cam_q;
  logic signed [35:0] px_q, py_q;
  logic [31:0]        dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cam_en) begin
      cam_q <= cam_prod[CAM_SH +: 18] - 18'h10000;
    end
    if (ctl_i.div_cap) begin
      case (ctl_i.div_sel)
        DIV_X:   dx_q <= recip_sat(mag_x, quot);
        DIV_Y:   dy_q <= recip_sat(mag_y, quot);
        default: dx_q <= dx_q;
      endcase
    end
    if (ctl_i.mul_en) begin
      px_q <= $signed(cfg_i.cam_plane_x) * cam_q;
      py_q <= $signed(cfg_i.cam_plane_y) * cam_q;
    end
    if (ctl_i.ray_en) begin
      rx_q <= 21'($signed(cfg_i.view_dir_x)) + 21'(px_q >>> 16);
      ry_q <= 21'($signed(cfg_i.view_dir_y)) + 21'(py_q >>> 16);
    end
  end

  // initial side distances
  logic [16:0] fsel_x, fsel_y;
  logic [48:0] prod_x, prod_y;

  assign fsel_x = rx_q[20] ? {1'b0, cfg_i.cam_pos_x[15:0]}
                           : 17'h10000 - {1'b0, cfg_i.cam_pos_x[15:0]};
  assign fsel_y = ry_q[20] ? {1'b0, cfg_i.cam_pos_y[15:0]}
                           : 17'h10000 - {1'b0, cfg_i.cam_pos_y[15:0]};
  assign prod_x = 49'(fsel_x) * 49'(dx_q);
  assign prod_y = 49'(fsel_y) * 49'(dy_q);

  // DDA step
  logic [31:0]        sdx_q, sdy_q, sdx_n, sdy_n;
  logic signed [CW-1:0] mx_q, my_q, mx_n, my_n;
  logic [1:0]         side_q, side_n;
  logic               oob_q, oob_n, go_x;
  logic [32:0]        sum_x, sum_y;
  logic signed [31:0] mxs, mys, posx, posy;
  logic [CB-1:0]      cols, rows;

  assign cols = (int'(cfg_i.map_cols) > MAP_DIM) ? CB'(MAP_DIM) : CB'(cfg_i.map_cols);
  assign rows = (int'(cfg_i.map_rows) > MAP_DIM) ? CB'(MAP_DIM) : CB'(cfg_i.map_rows);

  assign go_x  = sdx_q < sdy_q;
  assign sum_x = {1'b0, sdx_q} + {1'b0, dx_q};
  assign sum_y = {1'b0, sdy_q} + {1'b0, dy_q};
  assign posx  = $signed({10'b0, cfg_i.cam_pos_x});
  assign posy  = $signed({10'b0, cfg_i.cam_pos_y});
  assign mxs   = 32'(mx_n) <<< 16;
  assign mys   = 32'(my_n) <<< 16;

  always_comb begin
    mx_n  = mx_q;
    my_n  = my_q;
    sdx_n = sdx_q;
    sdy_n = sdy_q;
    if (go_x) begin
      sdx_n = sum_x[32] ? 32'hFFFF_FFFF : sum_x[31:0];
      mx_n  = rx_q[20] ? mx_q - CW'(1) : mx_q + CW'(1);
    end else begin
      sdy_n = sum_y[32] ? 32'hFFFF_FFFF : sum_y[31:0];
      my_n  = ry_q[20] ? my_q - CW'(1) : my_q + CW'(1);
    end
    if (go_x) begin
      side_n = (mxs < posx) ? SIDE_WEST : SIDE_EAST;
    end else begin
      side_n = (mys > posy) ? SIDE_NORTH : SIDE_SOUTH;
    end
  end

  assign oob_n = mx_n[CW-1] || (mx_n[CB-1:0] >= cols)
              || my_n[CW-1] || (my_n[CB-1:0] >= rows);
  assign raddr = AW'(AW'(my_n[CB-1:0]) * AW'(MAP_DIM) + AW'(mx_n[CB-1:0]));

  always_ff @(posedge clk_i) begin
    if (ctl_i.side_en) begin
      sdx_q <= prod_x[47:16];
      sdy_q <= prod_y[47:16];
      mx_q  <= CW'(cfg_i.cam_pos_x[21:16]);
      my_q  <= CW'(cfg_i.cam_pos_y[21:16]);
    end else if (ctl_i.step_en) begin
      sdx_q  <= sdx_n;
      sdy_q  <= sdy_n;
      mx_q   <= mx_n;
      my_q   <= my_n;
      side_q <= side_n;
      oob_q  <= oob_n;
    end
    if (ctl_i.step_en && !oob_n) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result register
  gdr_out_t res_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q.wall_side         <= side_q;
      res_q.wall_hit          <= !oob_q;
      res_q.hit_cell_x        <= 8'(mx_q);
      res_q.hit_cell_y        <= 8'(my_q);
      res_q.final_side_dist_x <= sdx_q;
      res_q.final_side_dist_y <= sdy_q;
    end
  end

  assign res_o          = res_q;
  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.div_done = div_done;
  assign sts_o.oob      = oob_q;
  assign sts_o.wall     = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/gdr_ctrl.sv */
// ---------------------------------------------------------------------------
// gdr_ctrl
// Sequencer: map clearing sweep, ray set-up steps and the DDA walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              cmd_i,
  input  wire gdr_pkg::gdr_sts_t sts_i,
  output gdr_pkg::gdr_ctl_t      ctl_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import gdr_pkg::*;

  gdr_state_e state_q, state_d;
  logic       done_q, done_d;
  logic       stop;

  assign stop = sts_i.oob || sts_i.wall;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:      if (start_i && cmd_i == CMD_CAST) state_d = ST_MUL;
      ST_MUL:       state_d = ST_RAY;
      ST_RAY:       state_d = ST_DIVX_GO;
      ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
      ST_DIVX_WAIT: if (sts_i.div_done) state_d = ST_DIVY_GO;
      ST_DIVY_GO:   state_d = ST_DIVY_WAIT;
      ST_DIVY_WAIT: if (sts_i.div_done) state_d = ST_SIDE;
      ST_SIDE:      state_d = ST_STEP;
      ST_STEP:      state_d = ST_CHECK;
      ST_CHECK:     state_d = stop ? ST_IDLE : ST_STEP;
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.div_sel = DIV_X;
    done_d        = 1'b0;
    case (state_q)
      ST_CLEAR: ctl_o.clr_en = 1'b1;
      ST_IDLE:  ctl_o.cam_en = start_i && cmd_i == CMD_CAST;
      ST_MUL:   ctl_o.mul_en = 1'b1;
      ST_RAY:   ctl_o.ray_en = 1'b1;
      ST_DIVX_GO: begin
        ctl_o.div_sel   = DIV_X;
        ctl_o.div_start = 1'b1;
      end
      ST_DIVX_WAIT: begin
        ctl_o.div_sel = DIV_X;
        ctl_o.div_cap = sts_i.div_done;
      end
      ST_DIVY_GO: begin
        ctl_o.div_sel   = DIV_Y;
        ctl_o.div_start = 1'b1;
      end
      ST_DIVY_WAIT: begin
        ctl_o.div_sel = DIV_Y;
        ctl_o.div_cap = sts_i.div_done;
      end
      ST_SIDE: ctl_o.side_en = 1'b1;
      ST_STEP: ctl_o.step_en = 1'b1;
      ST_CHECK: begin
        ctl_o.emit = stop;
        done_d     = stop;
      end
      default: ctl_o.div_sel = DIV_X;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* tb/sv/grid_dda_ray_caster_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_dda_ray_caster_tb
// Self-checking bench: fills the wall map, casts rays under several camera
// and map settings, checks results against an internal predictor or fixed values.
// ---------------------------------------------------------------------------
module grid_dda_ray_caster_tb;
  import gdr_pkg::*;

  localparam int unsigned MAP_DIM      = MAP_DIM_DEF;
  localparam int unsigned SCREEN_WIDTH = SCREEN_WIDTH_DEF;
  localparam longint      SAT32        = 64'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          DRAIN_CYCLES = 500;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 220;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  gdr_in_t     in_i = '0;
  logic        done_o;
  gdr_out_t    res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_dda_ray_caster u_top (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // shadow of the block's state
  gdr_cfg_t  shadow_cfg;
  bit        wall_shadow [MAP_DIM*MAP_DIM];
  gdr_out_t  pending_hits [$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  int        idle_pct = 0;

  typedef struct {
    gdr_in_t  item;
    bit       typed;
    gdr_out_t res;
  } dir_row_t;

  function automatic gdr_in_t mk_item(logic c, int col, int cx, int cy, logic w);
    gdr_in_t it;
    it.cmd = c;
    it.column = col[8:0];
    it.cell_x = cx[5:0];
    it.cell_y = cy[5:0];
    it.cell_wall = w;
    return it;
  endfunction

  function automatic longint inv_dist(longint r);
    longint mag;
    longint q;
    mag = (r < 0) ? -r : r;
    if (mag == 0) return SAT32;
    q = (64'd1 << 32) / mag;
    return (q > SAT32) ? SAT32 : q;
  endfunction

  function automatic gdr_out_t trace_ray(gdr_in_t it);
    gdr_out_t o;
    longint col, cam, rx, ry, dx, dy, sdx, sdy, fx, fy;
    longint mx, my, sx, sy, cols, rows, px, py;
    logic [1:0] side;
    bit hit;
    side = SIDE_WEST;
    hit = 0;
    col = it.column;
    if (col >= SCREEN_WIDTH) col = SCREEN_WIDTH - 1;
    cam = (col * 131072) / SCREEN_WIDTH - 65536;
    rx = longint'($signed(shadow_cfg.view_dir_x))
       + ((longint'($signed(shadow_cfg.cam_plane_x)) * cam) >>> 16);
    ry = longint'($signed(shadow_cfg.view_dir_y))
       + ((longint'($signed(shadow_cfg.cam_plane_y)) * cam) >>> 16);
    dx = inv_dist(rx);
    dy = inv_dist(ry);
    px = shadow_cfg.cam_pos_x;
    py = shadow_cfg.cam_pos_y;
    mx = px >> 16;
    my = py >> 16;
    fx = px & 16'hFFFF;
    fy = py & 16'hFFFF;
    if (rx < 0) begin sx = -1; sdx = (fx * dx) >> 16; end
    else begin sx = 1; sdx = ((65536 - fx) * dx) >> 16; end
    if (ry < 0) begin sy = -1; sdy = (fy * dy) >> 16; end
    else begin sy = 1; sdy = ((65536 - fy) * dy) >> 16; end
    cols = (shadow_cfg.map_cols > MAP_DIM) ? MAP_DIM : shadow_cfg.map_cols;
    rows = (shadow_cfg.map_rows > MAP_DIM) ? MAP_DIM : shadow_cfg.map_rows;
    forever begin
      if (sdx < sdy) begin
        sdx = sdx + dx;
        if (sdx > SAT32) sdx = SAT32;
        mx += sx;
        side = (mx * 65536 < px) ? SIDE_WEST : SIDE_EAST;
      end else begin
        sdy = sdy + dy;
        if (sdy > SAT32) sdy = SAT32;
        my += sy;
        side = (my * 65536 > py) ? SIDE_NORTH : SIDE_SOUTH;
      end
      if (mx < 0 || mx >= cols || my < 0 || my >= rows) break;
      if (wall_shadow[my * MAP_DIM + mx]) begin
        hit = 1;
        break;
      end
    end
    o.wall_side = side;
    o.wall_hit = hit;
    o.hit_cell_x = mx[7:0];
    o.hit_cell_y = my[7:0];
    o.final_side_dist_x = sdx[31:0];
    o.final_side_dist_y = sdy[31:0];
    return o;
  endfunction

  // result checker: no stall possible, every strobe is a beat
  always @(posedge clk_i) begin
    gdr_out_t want;
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        want = pending_hits.pop_front();
        if (res_o.wall_side !== want.wall_side) begin
          $error("wall_side exp %0d got %0d", want.wall_side, res_o.wall_side);
          n_errors++;
        end
        if (res_o.wall_hit !== want.wall_hit) begin
          $error("wall_hit exp %0d got %0d", want.wall_hit, res_o.wall_hit);
          n_errors++;
        end
        if (res_o.hit_cell_x !== want.hit_cell_x) begin
          $error("hit_cell_x exp %0d got %0d", $signed(want.hit_cell_x),
                 $signed(res_o.hit_cell_x));
          n_errors++;
        end
        if (res_o.hit_cell_y !== want.hit_cell_y) begin
          $error("hit_cell_y exp %0d got %0d", $signed(want.hit_cell_y),
                 $signed(res_o.hit_cell_y));
          n_errors++;
        end
        if (res_o.final_side_dist_x !== want.final_side_dist_x) begin
          $error("final_side_dist_x exp %h got %h", want.final_side_dist_x,
                 res_o.final_side_dist_x);
          n_errors++;
        end
        if (res_o.final_side_dist_y !== want.final_side_dist_y) begin
          $error("final_side_dist_y exp %h got %h", want.final_side_dist_y,
                 res_o.final_side_dist_y);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // start stays high across back-to-back beats; lowered only for a gap
  task automatic issue_cmd(gdr_in_t it, bit typed, gdr_out_t typed_res);
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.cmd == CMD_WRITE) begin
      wall_shadow[it.cell_y * MAP_DIM + it.cell_x] = it.cell_wall;
    end else begin
      pending_hits.push_back(typed ? typed_res : trace_ray(it));
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending_hits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAP_COLS:    shadow_cfg.map_cols = val[6:0];
      REG_MAP_ROWS:    shadow_cfg.map_rows = val[6:0];
      REG_CAM_POS_X:   shadow_cfg.cam_pos_x = val[21:0];
      REG_CAM_POS_Y:   shadow_cfg.cam_pos_y = val[21:0];
      REG_VIEW_DIR_X:  shadow_cfg.view_dir_x = val[17:0];
      REG_VIEW_DIR_Y:  shadow_cfg.view_dir_y = val[17:0];
      REG_CAM_PLANE_X: shadow_cfg.cam_plane_x = val[17:0];
      default:         shadow_cfg.cam_plane_y = val[17:0];
    endcase
  endtask

  function automatic logic [31:0] pick_size(int ph);
    case (ph % 5)
      0: return 32'd64;
      1: return 32'd1;
      2: return 32'd127;
      3: return 32'd0;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'h3F_FFFF;
      default: return $urandom_range(0, 32'h3F_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_vec();
    case ($urandom_range(9))
      0: return 32'h2_0000;
      1: return 32'h1_FFFF;
      2: return 32'd0;
      default: return $urandom_range(0, 32'h3_FFFF);
    endcase
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    gdr_out_t none;
    gdr_in_t  it;
    none = '0;
    shadow_cfg.map_cols = 7'd64;
    shadow_cfg.map_rows = 7'd64;
    shadow_cfg.cam_pos_x = 22'd98304;
    shadow_cfg.cam_pos_y = 22'd98304;
    shadow_cfg.view_dir_x = 18'd65536;
    shadow_cfg.view_dir_y = 18'd0;
    shadow_cfg.cam_plane_x = 18'd0;
    shadow_cfg.cam_plane_y = 18'd43254;
    foreach (wall_shadow[k]) wall_shadow[k] = 0;

    // centre ray on an empty map runs east out of the map along row 1
    r.item = mk_item(CMD_CAST, 256, 0, 0, 0); r.typed = 1;
    r.res = '{SIDE_EAST, 1'b0, 8'd64, 8'd1, 32'h003F_8000, 32'h7FFF_FFFF};
    rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 5, 1, 1); r.typed = 0; r.res = none;
    rows.push_back(r);
    r.item = mk_item(CMD_CAST, 256, 0, 0, 0); r.typed = 1;
    r.res = '{SIDE_EAST, 1'b1, 8'd5, 8'd1, 32'h0004_8000, 32'h7FFF_FFFF};
    rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 5, 1, 0); r.typed = 0; r.res = none;
    rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 511, 63, 63, 1); rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 0, 0, 1); rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 63, 0, 1); rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 0, 63, 1); rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 20, 1, 1); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 0, 0, 0, 0); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 511, 63, 63, 1); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 256, 0, 0, 0); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 128, 0, 0, 0); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 384, 0, 0, 0); rows.push_back(r);
    r.item = mk_item(CMD_WRITE, 0, 20, 1, 0); rows.push_back(r);
    r.item = mk_item(CMD_CAST, 255, 0, 0, 0); rows.push_back(r);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[k]) issue_cmd(rows[k].item, rows[k].typed, rows[k].res);
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // receiver cannot stall: even phases run with the sender busy throughout
      idle_pct = (ph % 4 == 1) ? 59 : ((ph % 4 == 3) ? 26 : 0);
      apb_write(REG_MAP_COLS, pick_size(ph));
      apb_write(REG_MAP_ROWS, pick_size(ph + 2));
      apb_write(REG_CAM_POS_X, pick_pos());
      apb_write(REG_CAM_POS_Y, pick_pos());
      apb_write(REG_VIEW_DIR_X, pick_vec());
      apb_write(REG_VIEW_DIR_Y, pick_vec());
      apb_write(REG_CAM_PLANE_X, pick_vec());
      apb_write(REG_CAM_PLANE_Y, pick_vec());
      // sparse walls so rays travel a fair way before striking one
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = mk_item($urandom_range(1), $urandom_range(511), $urandom_range(63),
                     $urandom_range(63), ($urandom_range(99) < 25));
        issue_cmd(it, 0, none);
      end
      settle();
    end

    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
